### sv/sync_length_packet_deframer_unit_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slpd check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SLPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slpd check failed");

`endif

### sv/slpd_pkg.sv
`default_nettype none
package slpd_pkg;

  // frame recognizer phases
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_LEADIN   = 3'd1;
  localparam logic [2:0] PH_ADDRTYPE = 3'd2;
  localparam logic [2:0] PH_SIZE     = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;
  localparam logic [2:0] PH_COMPLETE = 3'd5;
  localparam logic [2:0] PH_TIMEOUT  = 3'd6;

  // item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // register indexes
  localparam logic [1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [1:0] CFG_LEADIN_BYTE = 2'd1;
  localparam logic [1:0] CFG_MAX_SIZE    = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd3;

  localparam logic [7:0]  RST_START_BYTE  = 8'd187;
  localparam logic [7:0]  RST_LEADIN_BYTE = 8'd136;
  localparam logic [7:0]  RST_MAX_SIZE    = 8'd64;
  localparam logic [15:0] RST_TIMEOUT     = 16'd5;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  leadin_byte;
    logic [7:0]  max_data_size;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] frame_state;
    logic       data_valid;
    logic [7:0] data_out;
    logic [7:0] addr_type;
    logic [7:0] payload_length;
  } res_t;

endpackage
`default_nettype wire

### sv/slpd_cfg_regs.sv
`default_nettype none
module slpd_cfg_regs
  import slpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= RST_START_BYTE;
      cfg_r.leadin_byte   <= RST_LEADIN_BYTE;
      cfg_r.max_data_size <= RST_MAX_SIZE;
      cfg_r.timeout_ticks <= RST_TIMEOUT;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_START_BYTE:  cfg_r.start_byte    <= cfg_wdata[7:0];
        CFG_LEADIN_BYTE: cfg_r.leadin_byte   <= cfg_wdata[7:0];
        CFG_MAX_SIZE:    cfg_r.max_data_size <= cfg_wdata[7:0];
        CFG_TIMEOUT:     cfg_r.timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### sv/slpd_fsm.sv
`default_nettype none
module slpd_fsm
  import slpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       step_en,   // commit this item
  input  wire logic       item_op,
  input  wire logic [7:0] item_byte,
  output res_t            res
);

  logic [2:0]  phase_r,  phase_nxt;
  logic [7:0]  addr_r,   addr_nxt;
  logic [7:0]  len_r,    len_nxt;
  logic [7:0]  left_r,   left_nxt;
  logic [7:0]  last_r,   last_nxt;
  logic [15:0] timer_r,  timer_nxt;
  logic        valid;
  logic [2:0]  ph;

  always_comb begin
    // complete / timeout last one item
    ph = phase_r;
    if (phase_r == PH_COMPLETE || phase_r == PH_TIMEOUT || phase_r > PH_TIMEOUT) begin
      ph = PH_START;
    end
    phase_nxt = ph;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    last_nxt  = last_r;
    timer_nxt = timer_r;
    valid     = 1'b0;

    if (item_op == OP_BYTE) begin
      unique case (ph)
        PH_START: begin
          if (item_byte == cfg.start_byte) phase_nxt = PH_LEADIN;
        end
        PH_LEADIN: begin
          phase_nxt = (item_byte == cfg.leadin_byte) ? PH_ADDRTYPE : PH_START;
        end
        PH_ADDRTYPE: begin
          addr_nxt  = item_byte;
          phase_nxt = PH_SIZE;
        end
        PH_SIZE: begin
          len_nxt  = item_byte;
          left_nxt = item_byte;
          if (item_byte > cfg.max_data_size) phase_nxt = PH_START;
          else if (item_byte != 8'd0)        phase_nxt = PH_DATA;
          else                               phase_nxt = PH_COMPLETE;
        end
        PH_DATA: begin
          left_nxt = left_r - 8'd1;
          last_nxt = item_byte;
          valid    = 1'b1;
          if (left_r == 8'd1) phase_nxt = PH_COMPLETE;
        end
        default: ;
      endcase
      if (phase_nxt != PH_START) timer_nxt = cfg.timeout_ticks;
    end else if (ph != PH_START) begin
      if (timer_r[15:1] == 15'd0) begin
        timer_nxt = 16'd0;
        phase_nxt = PH_TIMEOUT;
      end else begin
        timer_nxt = timer_r - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      addr_r  <= 8'd0;
      len_r   <= 8'd0;
      left_r  <= 8'd0;
      last_r  <= 8'd0;
      timer_r <= 16'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      last_r  <= last_nxt;
      timer_r <= timer_nxt;
    end
  end

  always_comb begin
    res.frame_state    = phase_nxt;
    res.data_valid     = valid;
    res.data_out       = last_nxt;
    res.addr_type      = addr_nxt;
    res.payload_length = len_nxt;
  end

endmodule
`default_nettype wire

### sv/sync_length_packet_deframer_unit.sv
// Length-prefixed frame deframer with idle timeout. Each input transaction
// is a received byte (in_tuser = 0) or one time tick (in_tuser = 1); each
// one produces exactly one output transaction with the recognizer phase after
// that item, a payload-valid flag and the held payload/header bytes. Frames
// are start byte, lead-in byte, address/type byte, length byte, then that
// many payload bytes. An item goes through an input register, the next-state
// logic and an output register; one item is taken every cycle, also while an
// unread result sits in the output register, as long as that result drains in
// the same cycle. Configuration registers (0 start byte, 1 lead-in byte, 2 max
// payload size, 3 timeout ticks) are written through cfg_wr_en/cfg_addr/
// cfg_wdata; the user must write them only while idle; the block does not enforce it.
`default_nettype none
module sync_length_packet_deframer_unit
  import slpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config write port
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] operation
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [2:0] frame_state, [10:3] data_out,
                                       // [18:11] addr_type,
                                       // [26:19] payload_length, rest zero
  output logic             out_tuser   // [0] data_valid
);

  cfg_t cfg;
  res_t res;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;

  // output register
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;

  logic advance;   // held item moves into the output register

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) s1_valid_nxt = 1'b1;
    else if (advance)           s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser;
      s1_byte_r <= in_tdata;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  slpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slpd_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step_en   (advance),
    .item_op   (s1_op_r),
    .item_byte (s1_byte_r),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.payload_length, out_res_r.addr_type,
                       out_res_r.data_out, out_res_r.frame_state};
  assign out_tuser  = out_res_r.data_valid;

endmodule
`default_nettype wire

### sv/slpd_checker.sv
`default_nettype none
`include "sync_length_packet_deframer_unit_defines.svh"
module slpd_checker
  import slpd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  logic [2:0] fs;
  logic       fs_pay;
  logic       in_seen;

  assign fs      = out_tdata[2:0];
  assign fs_pay  = (fs == PH_DATA) || (fs == PH_COMPLETE);
  assign in_seen = in_tvalid && in_tready;

  // stalled result stays up and unchanged
  `SLPD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `SLPD_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))
  // a payload byte only appears in the data phase or when it closes the frame
  `SLPD_ASSERT_IMP(a_pay_phase, out_tvalid && out_tuser, fs_pay)
  // a payload byte implies a nonzero announced length
  `SLPD_ASSERT_IMP(a_pay_len, out_tvalid && out_tuser && in_seen || out_tvalid && out_tuser, out_tdata[26:19] != 8'd0)

endmodule

bind sync_length_packet_deframer_unit slpd_checker u_slpd_checker (.*);
`default_nettype wire

### tb/tb_sync_length_packet_deframer_unit.sv
`timescale 1ns / 100ps

// Frame deframer bench. Stimulus is a mix of well-formed frames with random
// content, broken frames (bad lead-in, oversized length, timed-out frames) and
// line noise. Every accepted input transaction runs through a local copy of
// the recognizer, whose result is queued and compared field by field with the
// next output transaction.
module tb_sync_length_packet_deframer_unit;
  import slpd_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned PIPE_LATENCY = 2;      // input reg + output reg
  localparam int unsigned DRAIN_CYCLES = 8 * PIPE_LATENCY;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned BULK_ITEMS   = 500;    // non-ignored items, bulk phase
  localparam int unsigned RECONFIG_GAP = 150;
  localparam int unsigned GAP_MAX      = 14;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned MAX_REPORTS  = 40;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        in_tuser;   // [0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [2:0] frame_state, [10:3] data_out, [18:11] addr_type,
                           // [26:19] payload_length, rest zero
  logic        out_tuser;  // [0] data_valid

  // Predictor copy of the register file
  logic [7:0]  exp_start_byte;
  logic [7:0]  exp_leadin_byte;
  logic [7:0]  exp_max_size;
  logic [15:0] exp_timeout;

  // Predictor copy of the recognizer state
  logic [2:0]  rx_phase;
  logic [7:0]  rx_addr;
  logic [7:0]  rx_length;
  logic [7:0]  rx_left;
  logic [7:0]  rx_payload;
  logic [15:0] rx_idle;

  res_t        expected_frame_results[$];

  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned active_items  = 0;  // items that moved the recognizer
  int unsigned cycle_count   = 0;
  int unsigned in_gap_max    = GAP_MAX;
  int unsigned out_gap_max   = GAP_MAX;
  int unsigned sink_hold_req = 0;  // one-shot long stall for the result sink

  sync_length_packet_deframer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sync_length_packet_deframer_unit NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic reset_frame_model();
    exp_start_byte  = RST_START_BYTE;
    exp_leadin_byte = RST_LEADIN_BYTE;
    exp_max_size    = RST_MAX_SIZE;
    exp_timeout     = RST_TIMEOUT;
    rx_phase   = PH_START;
    rx_addr    = 8'h00;
    rx_length  = 8'h00;
    rx_left    = 8'h00;
    rx_payload = 8'h00;
    rx_idle    = 16'h0000;
  endtask

  // One recognizer step; queues the result this transaction must produce.
  task automatic predict_frame_step(input logic op, input logic [7:0] rx);
    logic [2:0] entry_phase;
    logic       delivered;
    res_t       res;
    entry_phase = rx_phase;
    delivered   = 1'b0;
    // complete/timeout last one item, then the item is handled as in start
    if (rx_phase == PH_COMPLETE || rx_phase == PH_TIMEOUT || rx_phase > PH_TIMEOUT)
      rx_phase = PH_START;
    if (op == OP_BYTE) begin
      case (rx_phase)
        PH_START: begin
          if (rx == exp_start_byte) rx_phase = PH_LEADIN;
        end
        PH_LEADIN: begin
          rx_phase = (rx == exp_leadin_byte) ? PH_ADDRTYPE : PH_START;
        end
        PH_ADDRTYPE: begin
          rx_addr  = rx;
          rx_phase = PH_SIZE;
        end
        PH_SIZE: begin
          // length is kept even when it is too large
          rx_length = rx;
          rx_left   = rx;
          if (rx > exp_max_size) rx_phase = PH_START;
          else if (rx != 8'h00) rx_phase = PH_DATA;
          else rx_phase = PH_COMPLETE;
        end
        PH_DATA: begin
          rx_left    = rx_left - 8'h01;
          rx_payload = rx;
          delivered  = 1'b1;
          if (rx_left == 8'h00) rx_phase = PH_COMPLETE;
        end
        default: begin
        end
      endcase
      // any byte that leaves the recognizer out of start reloads the timer
      if (rx_phase != PH_START) rx_idle = exp_timeout;
    end else if (rx_phase != PH_START) begin
      if (rx_idle <= 16'd1) begin
        rx_idle  = 16'd0;
        rx_phase = PH_TIMEOUT;
      end else begin
        rx_idle = rx_idle - 16'd1;
      end
    end
    res.frame_state    = rx_phase;
    res.data_valid     = delivered;
    res.data_out       = rx_payload;
    res.addr_type      = rx_addr;
    res.payload_length = rx_length;
    expected_frame_results.push_back(res);
    if (!(entry_phase == PH_START && rx_phase == PH_START)) active_items++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("MISMATCH @%0t result #%0d %s: got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_frame_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata, 32'h0);
      end else begin
        want = expected_frame_results.pop_front();
        if (out_tdata[2:0] !== want.frame_state)
          report_mismatch("frame_state", 32'(out_tdata[2:0]), 32'(want.frame_state));
        if (out_tuser !== want.data_valid)
          report_mismatch("data_valid", 32'(out_tuser), 32'(want.data_valid));
        if (out_tdata[10:3] !== want.data_out)
          report_mismatch("data_out", 32'(out_tdata[10:3]), 32'(want.data_out));
        if (out_tdata[18:11] !== want.addr_type)
          report_mismatch("addr_type", 32'(out_tdata[18:11]), 32'(want.addr_type));
        if (out_tdata[26:19] !== want.payload_length)
          report_mismatch("payload_length", 32'(out_tdata[26:19]),
                          32'(want.payload_length));
        if (out_tdata[31:27] !== 5'd0)
          report_mismatch("tdata padding", 32'(out_tdata[31:27]), 32'h0);
      end
      results_seen++;
    end
  end

  function automatic int unsigned draw_gap(input int unsigned gap_max);
    return $urandom_range(0, gap_max);
  endfunction

  // Result sink: random stall before each transaction; a requested long hold
  // replaces one draw and is counted out here, cycle by cycle.
  initial begin : result_sink
    int unsigned pause;
    int unsigned held;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      pause = draw_gap(out_gap_max);
      if (sink_hold_req != 0) begin
        pause         = sink_hold_req;
        sink_hold_req = 0;
      end
      if (pause != 0) begin
        out_tready <= 1'b0;
        for (held = 0; held < pause; held++) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one item and returns in the step of its acceptance edge. tvalid
  // stays high into the next call when that call draws no gap.
  task automatic send_item(input logic op, input logic [7:0] rx);
    int unsigned gap;
    gap = draw_gap(in_gap_max);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_frame_step(op, rx);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(0, 255)));  // byte lane is don't-care
  endtask

  // Drop tvalid and wait until every queued result has been seen.
  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_frame_results.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
  endtask

  // Writes all four registers back to back; 8-bit registers get junk in the
  // upper half of the write word, which the block must drop.
  task automatic apply_config(input logic [7:0] sb, input logic [7:0] lb,
                              input logic [7:0] ms, input logic [15:0] to);
    logic [1:0]  reg_idx [4];
    logic [15:0] reg_word [4];
    reg_idx[0]  = CFG_START_BYTE;
    reg_idx[1]  = CFG_LEADIN_BYTE;
    reg_idx[2]  = CFG_MAX_SIZE;
    reg_idx[3]  = CFG_TIMEOUT;
    reg_word[0] = {8'($urandom_range(0, 255)), sb};
    reg_word[1] = {8'($urandom_range(0, 255)), lb};
    reg_word[2] = {8'($urandom_range(0, 255)), ms};
    reg_word[3] = to;
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= reg_idx[i];
      cfg_wdata <= reg_word[i];
      @(posedge clk);
      case (reg_idx[i])
        CFG_START_BYTE:  exp_start_byte  = reg_word[i][7:0];
        CFG_LEADIN_BYTE: exp_leadin_byte = reg_word[i][7:0];
        CFG_MAX_SIZE:    exp_max_size    = reg_word[i][7:0];
        CFG_TIMEOUT:     exp_timeout     = reg_word[i];
        default: begin
        end
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_random_config();
    logic [7:0]  ms;
    logic [15:0] to;
    case ($urandom_range(0, 9))
      0:       ms = 8'h00;
      1:       ms = 8'hFF;
      default: ms = 8'($urandom_range(4, 64));
    endcase
    case ($urandom_range(0, 9))
      0:       to = 16'd1;
      1:       to = 16'($urandom_range(1, 65535));
      default: to = 16'($urandom_range(2, 10));
    endcase
    apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), ms, to);
  endtask

  // A few ticks that stay short of the timeout, now and then.
  task automatic maybe_idle_ticks();
    int unsigned n;
    if (exp_timeout > 16'd1 && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, (exp_timeout > 16'd4) ? 3 : exp_timeout - 1);
      repeat (n) send_tick();
    end
  endtask

  // Well-formed header and payload of len bytes. With cut_at >= 0 the frame
  // is abandoned after cut_at payload bytes and ticked out to a timeout.
  task automatic send_frame(input int unsigned len, input int cut_at);
    send_item(OP_BYTE, exp_start_byte);
    maybe_idle_ticks();
    send_item(OP_BYTE, exp_leadin_byte);
    maybe_idle_ticks();
    send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    maybe_idle_ticks();
    send_item(OP_BYTE, 8'(len));
    for (int i = 0; i < int'(len); i++) begin
      if (i == cut_at) begin
        repeat (exp_timeout) send_tick();
        return;
      end
      maybe_idle_ticks();
      send_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly good frames with random content; the rest is broken or noise.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned cap;
    logic [7:0]  lead;
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      // line noise: stray bytes and ticks
      repeat ($urandom_range(1, 5))
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end else if (pick >= 84) begin
      // bad lead-in
      lead = 8'($urandom_range(0, 255));
      if (lead == exp_leadin_byte) lead = ~lead;
      send_item(OP_BYTE, exp_start_byte);
      send_item(OP_BYTE, lead);
    end else if (pick >= 78 && exp_max_size != 8'hFF) begin
      // oversized length
      send_item(OP_BYTE, exp_start_byte);
      send_item(OP_BYTE, exp_leadin_byte);
      send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      send_item(OP_BYTE, 8'($urandom_range(int'(exp_max_size) + 1, 255)));
    end else begin
      cap = (exp_max_size < 8'd12) ? exp_max_size : 12;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, exp_max_size)
                                         : $urandom_range(0, cap);
      // frames that die of a timeout, only where the tick count is short
      if (pick >= 70 && len != 0 && exp_timeout <= 16'd16)
        send_frame(len, $urandom_range(0, len - 1));
      else
        send_frame(len, -1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values, every special case of the recognizer in turn.
  task automatic test_reset_defaults();
    send_tick();                              // tick with no frame open
    send_item(OP_BYTE, 8'h00);                // stray byte
    send_item(OP_BYTE, RST_START_BYTE);
    send_item(OP_BYTE, 8'h00);                // wrong lead-in
    send_item(OP_BYTE, RST_START_BYTE);
    send_item(OP_BYTE, RST_LEADIN_BYTE);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);                // zero length -> complete
    send_item(OP_BYTE, RST_START_BYTE);       // start byte right after complete
    send_item(OP_BYTE, RST_LEADIN_BYTE);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, RST_MAX_SIZE + 8'd1);  // oversized, length still held
    send_item(OP_BYTE, RST_START_BYTE);
    send_item(OP_BYTE, RST_LEADIN_BYTE);
    send_item(OP_BYTE, 8'h5A);
    send_item(OP_BYTE, 8'd2);
    send_item(OP_BYTE, 8'h00);
    send_tick();                              // timer counts down, no timeout
    send_tick();
    send_item(OP_BYTE, 8'hFF);                // last byte reloads, completes
    send_item(OP_TICK, 8'h00);                // tick right after complete
    send_item(OP_BYTE, RST_START_BYTE);
    repeat (RST_TIMEOUT) send_tick();         // idle out -> timeout
    send_item(OP_BYTE, RST_START_BYTE);       // start byte right after timeout
    wait_until_idle();
  endtask

  // Register extremes: smallest limits, then largest.
  task automatic test_register_extremes();
    apply_config(8'h00, 8'hFF, 8'h00, 16'd1);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h81);
    send_item(OP_BYTE, 8'h00);                // only length 0 fits
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h42);
    send_item(OP_BYTE, 8'h01);                // oversized at max 0
    send_item(OP_BYTE, 8'h00);
    send_tick();                              // timeout of 1: first tick kills it
    repeat (20) send_random_frame();
    wait_until_idle();

    apply_config(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
    send_frame(255, -1);                      // longest payload
    repeat (10) send_random_frame();
    wait_until_idle();
  endtask

  // Receiver stalls long while the sender pushes back to back; the pipe
  // fills and in_tready must drop without losing anything.
  task automatic test_output_backpressure();
    apply_config(RST_START_BYTE, RST_LEADIN_BYTE, 8'd16, 16'd8);
    in_gap_max    = 0;
    sink_hold_req = LONG_HOLD;
    repeat (12) send_random_frame();
    in_gap_max = GAP_MAX;
    wait_until_idle();
  endtask

  // Bulk random traffic, with register changes at idle points and
  // stretches where one or both sides run without gaps.
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned next_reconfig;
    target        = active_items + BULK_ITEMS;
    next_reconfig = active_items + RECONFIG_GAP;
    while (active_items < target) begin
      if (active_items >= next_reconfig) begin
        wait_until_idle();
        apply_random_config();
        next_reconfig = active_items + RECONFIG_GAP;
      end
      if ($urandom_range(0, 9) == 0) in_gap_max  = $urandom_range(0, 1) ? GAP_MAX : 0;
      if ($urandom_range(0, 9) == 0) out_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
      send_random_frame();
    end
    in_gap_max  = GAP_MAX;
    out_gap_max = GAP_MAX;
    wait_until_idle();
  endtask

  initial begin : test_sequence
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= CFG_START_BYTE;
    cfg_wdata <= 16'h0000;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= OP_BYTE;
    reset_frame_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_frame_results.size() == 0) begin
      $display("tb_sync_length_packet_deframer_unit OK");
    end else begin
      $display("tb_sync_length_packet_deframer_unit NOT OK");
    end
    $finish;
  end

endmodule

### sync_length_packet_deframer_unit.f
+incdir+sv
sv/slpd_pkg.sv
sv/slpd_cfg_regs.sv
sv/slpd_fsm.sv
sv/sync_length_packet_deframer_unit.sv
sv/slpd_checker.sv
tb/tb_sync_length_packet_deframer_unit.sv
